// ----- hw/rtl/ctsd_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Cartesian to spherical direction: shared types and constants
// Beat formats, cell state formats and the CORDIC arctangent table.
// ============================================================================
package ctsd_pkg;

    localparam int COORD_W     = 24;
    localparam int ANGLE_W     = 16;
    localparam int DIR_W       = 16;
    localparam int DIR_ONE     = 16384;
    localparam int DIV_BITS    = 15;
    localparam int GUARD_SHIFT = 24;
    localparam int CORD_W      = COORD_W + GUARD_SHIFT + 3;
    localparam int ACC_W       = 34;
    localparam int NUM_W       = COORD_W + 16;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int ANG_SHIFT   = 32 - ANGLE_W;

    localparam logic [COORD_W-1:0]      MIN_RANGE_RST   = COORD_W'(7);
    localparam logic                    REG_MIN_RANGE   = 1'b0;
    localparam logic signed [ACC_W-1:0] ANG_HALF        = ACC_W'(1) <<< (ANG_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] ANG_QUARTER_ACC = ACC_W'(1) <<< (ANGLE_W - 2);
    localparam logic signed [ACC_W-1:0] ANG_PI_HALF     = ACC_W'(1) <<< 30;
    localparam logic signed [ANGLE_W-1:0] ANG_QUARTER   = ANGLE_W'(1) <<< (ANGLE_W - 2);

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } point_t;

    typedef struct packed {
        logic        [COORD_W-1:0] range;
        logic signed [ANGLE_W-1:0] azimuth;
        logic signed [ANGLE_W-1:0] elevation;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic                      near_origin;
    } result_t;

    typedef struct packed {
        logic [SQ_W-1:0]    rad;
        logic [COORD_W+1:0] rem;
        logic [COORD_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ACC_W-1:0]  ang;
    } cordic_t;

    typedef struct packed {
        logic [NUM_W-1:0]    rem;
        logic [COORD_W:0]    den;
        logic [DIV_BITS-1:0] quo;
        logic                neg;
    } div_t;

    typedef struct packed {
        logic [COORD_W-1:0] range;
        logic               near;
        logic               vert;
        logic               zneg;
    } post_sb_t;

    function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ACC_W-1:0] val;
        case (idx)
            5'd0:    val = ACC_W'(536870912);
            5'd1:    val = ACC_W'(316933406);
            5'd2:    val = ACC_W'(167458907);
            5'd3:    val = ACC_W'(85004756);
            5'd4:    val = ACC_W'(42667331);
            5'd5:    val = ACC_W'(21354465);
            5'd6:    val = ACC_W'(10679838);
            5'd7:    val = ACC_W'(5340245);
            5'd8:    val = ACC_W'(2670163);
            5'd9:    val = ACC_W'(1335087);
            5'd10:   val = ACC_W'(667544);
            5'd11:   val = ACC_W'(333772);
            5'd12:   val = ACC_W'(166886);
            5'd13:   val = ACC_W'(83443);
            5'd14:   val = ACC_W'(41722);
            5'd15:   val = ACC_W'(20861);
            5'd16:   val = ACC_W'(10430);
            5'd17:   val = ACC_W'(5215);
            5'd18:   val = ACC_W'(2608);
            5'd19:   val = ACC_W'(1304);
            5'd20:   val = ACC_W'(652);
            5'd21:   val = ACC_W'(326);
            5'd22:   val = ACC_W'(163);
            5'd23:   val = ACC_W'(81);
            default: val = '0;
        endcase
        return val;
    endfunction

    // Scales the vector up and folds the left half plane onto the right one.
    function automatic cordic_t cordic_init(input logic signed [COORD_W:0] x_in,
                                            input logic signed [COORD_W:0] y_in);
        cordic_t                  res;
        logic signed [CORD_W-1:0] xw;
        logic signed [CORD_W-1:0] yw;
        xw = CORD_W'(x_in);
        yw = CORD_W'(y_in);
        xw = xw <<< GUARD_SHIFT;
        yw = yw <<< GUARD_SHIFT;
        res.x   = xw;
        res.y   = yw;
        res.ang = '0;
        if (xw < 0) begin
            if (yw >= 0) begin
                res.ang = ANG_PI_HALF;
                res.x   = yw;
                res.y   = -xw;
            end else begin
                res.ang = -ANG_PI_HALF;
                res.x   = -yw;
                res.y   = xw;
            end
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/ctsd_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Square root cell
// Resolves one root bit per beat from the next two radicand bits.
// ============================================================================
module ctsd_sqrt_cell (
    input  logic            clk,
    input  logic            en,
    input  ctsd_pkg::sqrt_t d_in,
    output ctsd_pkg::sqrt_t d_out
);

    localparam int W = ctsd_pkg::COORD_W;

    ctsd_pkg::sqrt_t out_reg;
    ctsd_pkg::sqrt_t out_next;
    logic [W+3:0]    shf;
    logic [W+3:0]    trial;

    always_comb
    begin
        shf   = {d_in.rem, d_in.rad[ctsd_pkg::SQ_W-1 -: 2]};
        trial = (W + 4)'({d_in.root, 2'b01});
        out_next.rad = {d_in.rad[ctsd_pkg::SQ_W-3:0], 2'b00};
        if (shf >= trial)
        begin
            out_next.rem  = (W + 2)'(shf - trial);
            out_next.root = {d_in.root[W-2:0], 1'b1};
        end
        else
        begin
            out_next.rem  = shf[W+1:0];
            out_next.root = {d_in.root[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

// ----- hw/rtl/ctsd_cordic_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// CORDIC vectoring cell
// One micro-rotation toward the positive x axis, accumulating the angle; an inactive cell passes its input through.
// ============================================================================
module ctsd_cordic_cell #(
    parameter int SHIFT  = 0,
    parameter bit ACTIVE = 1'b1
) (
    input  logic              clk,
    input  logic              en,
    input  ctsd_pkg::cordic_t d_in,
    output ctsd_pkg::cordic_t d_out
);

    ctsd_pkg::cordic_t                  out_reg;
    ctsd_pkg::cordic_t                  out_next;
    logic signed [ctsd_pkg::CORD_W-1:0] xi;
    logic signed [ctsd_pkg::CORD_W-1:0] yi;
    logic signed [ctsd_pkg::CORD_W-1:0] xs;
    logic signed [ctsd_pkg::CORD_W-1:0] ys;
    logic signed [ctsd_pkg::ACC_W-1:0]  ai;
    logic signed [ctsd_pkg::ACC_W-1:0]  step;

    always_comb
    begin
        xi   = d_in.x;
        yi   = d_in.y;
        ai   = d_in.ang;
        xs   = xi >>> SHIFT;
        ys   = yi >>> SHIFT;
        step = ctsd_pkg::atan_entry(5'(SHIFT));
        out_next = d_in;
        if (ACTIVE)
        begin
            if (yi >= 0)
            begin
                out_next.x   = xi + ys;
                out_next.y   = yi - xs;
                out_next.ang = ai + step;
            end
            else
            begin
                out_next.x   = xi - ys;
                out_next.y   = yi + xs;
                out_next.ang = ai - step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

// ----- hw/rtl/ctsd_div_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Restoring divider cell
// Settles one quotient bit of a direction component per beat; an inactive cell passes its input through.
// ============================================================================
module ctsd_div_cell #(
    parameter int BIT    = 0,
    parameter bit ACTIVE = 1'b1
) (
    input  logic           clk,
    input  logic           en,
    input  ctsd_pkg::div_t d_in,
    output ctsd_pkg::div_t d_out
);

    ctsd_pkg::div_t                out_reg;
    ctsd_pkg::div_t                out_next;
    logic [ctsd_pkg::NUM_W-1:0]    dsh;

    always_comb
    begin
        dsh      = ctsd_pkg::NUM_W'(d_in.den) << BIT;
        out_next = d_in;
        if (ACTIVE && (d_in.rem >= dsh))
        begin
            out_next.rem      = d_in.rem - dsh;
            out_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

// ----- hw/rtl/cartesian_to_spherical_direction.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Cartesian to spherical direction converter
// Range, azimuth, elevation and unit direction of one point per beat.
// ============================================================================
// Throughput: one point per cycle; the squaring, square root cells, CORDIC cells
// and divider cells form one pipeline that advances while the skid slot is free.
// Reset clears the pipeline valid bits and the output and skid valid bits, and sets min_range to 7.
module cartesian_to_spherical_direction #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_ready,
    input  ctsd_pkg::point_t  point,
    output logic              result_valid,
    input  logic              result_ready,
    output ctsd_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW         = ctsd_pkg::COORD_W;
    localparam int POST_CELLS = (CORDIC_STAGES > ctsd_pkg::DIV_BITS) ?
                                CORDIC_STAGES : ctsd_pkg::DIV_BITS;
    localparam int NV         = 3 + CW + POST_CELLS;

    logic                       en;
    logic [NV-1:0]              v_reg;
    logic [CW-1:0]              min_range_reg;

    ctsd_pkg::point_t           pa_reg;
    ctsd_pkg::point_t           pb_reg;
    ctsd_pkg::point_t           pc_reg;
    logic [ctsd_pkg::SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [ctsd_pkg::SQ_W-1:0]  sqx_next, sqy_next, sqz_next;
    ctsd_pkg::sqrt_t            sr0_reg, sh0_reg, sr0_next, sh0_next;

    ctsd_pkg::sqrt_t            sr [CW+1];
    ctsd_pkg::sqrt_t            sh [CW+1];
    ctsd_pkg::point_t           pd_reg [CW];

    ctsd_pkg::cordic_t          az [POST_CELLS+1];
    ctsd_pkg::cordic_t          el [POST_CELLS+1];
    ctsd_pkg::div_t             dvx [POST_CELLS+1];
    ctsd_pkg::div_t             dvy [POST_CELLS+1];
    ctsd_pkg::div_t             dvz [POST_CELLS+1];
    ctsd_pkg::post_sb_t         ps_reg [POST_CELLS];
    ctsd_pkg::post_sb_t         ps_next;
    ctsd_pkg::cordic_t          az_init, el_init;
    ctsd_pkg::div_t             dvx_init, dvy_init, dvz_init;

    ctsd_pkg::result_t          fin;
    ctsd_pkg::result_t          out_reg, skid_reg;
    logic                       out_v_reg, skid_v_reg;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= ctsd_pkg::MIN_RANGE_RST;
        end
        else if (psel && penable && pwrite && (paddr[2] == ctsd_pkg::REG_MIN_RANGE))
        begin
            min_range_reg <= pwdata[CW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ctsd_pkg::REG_MIN_RANGE)
        begin
            prdata = 32'(min_range_reg);
        end
    end

    // Pipeline control.
    assign en          = !skid_v_reg;
    assign point_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NV-2:0], point_valid};
        end
    end

    // Squares and sums.
    always_comb
    begin
        logic signed [CW-1:0]   sx, sy, sz;
        logic signed [2*CW-1:0] px, py, pz;
        sx = pa_reg.pos_x;
        sy = pa_reg.pos_y;
        sz = pa_reg.pos_z;
        px = sx * sx;
        py = sy * sy;
        pz = sz * sz;
        sqx_next = px;
        sqy_next = py;
        sqz_next = pz;
    end

    always_comb
    begin
        sr0_next.rad  = sqx_reg + sqy_reg + sqz_reg;
        sr0_next.rem  = '0;
        sr0_next.root = '0;
        sh0_next.rad  = sqx_reg + sqy_reg;
        sh0_next.rem  = '0;
        sh0_next.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= point;
            pb_reg  <= pa_reg;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sqz_reg <= sqz_next;
            pc_reg  <= pb_reg;
            sr0_reg <= sr0_next;
            sh0_reg <= sh0_next;
            pd_reg[0] <= pc_reg;
            for (int k = 1; k < CW; k++)
            begin
                pd_reg[k] <= pd_reg[k-1];
            end
        end
    end

    // Square root chains for the range and the horizontal distance.
    assign sr[0] = sr0_reg;
    assign sh[0] = sh0_reg;

    for (genvar k = 0; k < CW; k++)
    begin : g_sqrt
        ctsd_sqrt_cell u_range (.clk(clk), .en(en), .d_in(sr[k]), .d_out(sr[k+1]));
        ctsd_sqrt_cell u_horiz (.clk(clk), .en(en), .d_in(sh[k]), .d_out(sh[k+1]));
    end

    // Setup of the angle and direction chains.
    always_comb
    begin
        logic [CW-1:0]        rr;
        logic [CW-1:0]        hh;
        logic signed [CW-1:0] cx, cy, cz;
        logic signed [CW:0]   ex, ey, ez;
        logic [CW-1:0]        mx, my, mz;
        rr = sr[CW].root;
        hh = sh[CW].root;
        cx = pd_reg[CW-1].pos_x;
        cy = pd_reg[CW-1].pos_y;
        cz = pd_reg[CW-1].pos_z;
        ex = (CW + 1)'(cx);
        ey = (CW + 1)'(cy);
        ez = (CW + 1)'(cz);
        mx = (cx < 0) ? CW'(-ex) : CW'(ex);
        my = (cy < 0) ? CW'(-ey) : CW'(ey);
        mz = (cz < 0) ? CW'(-ez) : CW'(ez);

        az_init = ctsd_pkg::cordic_init(ex, ey);
        el_init = ctsd_pkg::cordic_init({1'b0, hh}, ez);

        dvx_init.rem = (ctsd_pkg::NUM_W'(mx) << 15) + ctsd_pkg::NUM_W'(rr);
        dvx_init.den = {rr, 1'b0};
        dvx_init.quo = '0;
        dvx_init.neg = cx < 0;
        dvy_init.rem = (ctsd_pkg::NUM_W'(my) << 15) + ctsd_pkg::NUM_W'(rr);
        dvy_init.den = {rr, 1'b0};
        dvy_init.quo = '0;
        dvy_init.neg = cy < 0;
        dvz_init.rem = (ctsd_pkg::NUM_W'(mz) << 15) + ctsd_pkg::NUM_W'(rr);
        dvz_init.den = {rr, 1'b0};
        dvz_init.quo = '0;
        dvz_init.neg = cz < 0;

        ps_next.range = rr;
        ps_next.near  = (rr < min_range_reg) || (rr == '0);
        ps_next.vert  = (cx == '0) && (cy == '0);
        ps_next.zneg  = cz < 0;
    end

    assign az[0]  = az_init;
    assign el[0]  = el_init;
    assign dvx[0] = dvx_init;
    assign dvy[0] = dvy_init;
    assign dvz[0] = dvz_init;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg[0] <= ps_next;
            for (int j = 1; j < POST_CELLS; j++)
            begin
                ps_reg[j] <= ps_reg[j-1];
            end
        end
    end

    for (genvar j = 0; j < POST_CELLS; j++)
    begin : g_post
        localparam bit CORD_ON = j < CORDIC_STAGES;
        localparam bit DIV_ON  = j < ctsd_pkg::DIV_BITS;
        localparam int QBIT    = DIV_ON ? (ctsd_pkg::DIV_BITS - 1 - j) : 0;

        ctsd_cordic_cell #(.SHIFT(j), .ACTIVE(CORD_ON)) u_az (
            .clk(clk), .en(en), .d_in(az[j]), .d_out(az[j+1]));
        ctsd_cordic_cell #(.SHIFT(j), .ACTIVE(CORD_ON)) u_el (
            .clk(clk), .en(en), .d_in(el[j]), .d_out(el[j+1]));
        ctsd_div_cell #(.BIT(QBIT), .ACTIVE(DIV_ON)) u_dx (
            .clk(clk), .en(en), .d_in(dvx[j]), .d_out(dvx[j+1]));
        ctsd_div_cell #(.BIT(QBIT), .ACTIVE(DIV_ON)) u_dy (
            .clk(clk), .en(en), .d_in(dvy[j]), .d_out(dvy[j+1]));
        ctsd_div_cell #(.BIT(QBIT), .ACTIVE(DIV_ON)) u_dz (
            .clk(clk), .en(en), .d_in(dvz[j]), .d_out(dvz[j+1]));
    end

    // Rounding, clamping and origin handling.
    function automatic logic [ctsd_pkg::DIR_W-1:0] dir_value(input ctsd_pkg::div_t d);
        logic [ctsd_pkg::DIR_W-1:0] q;
        q = (d.quo > ctsd_pkg::DIR_ONE) ? ctsd_pkg::DIR_W'(ctsd_pkg::DIR_ONE)
                                        : ctsd_pkg::DIR_W'(d.quo);
        return d.neg ? -q : q;
    endfunction

    always_comb
    begin
        logic signed [ctsd_pkg::ACC_W-1:0] az_rnd;
        logic signed [ctsd_pkg::ACC_W-1:0] el_rnd;
        ctsd_pkg::post_sb_t                sb;
        sb     = ps_reg[POST_CELLS-1];
        az_rnd = (az[POST_CELLS].ang + ctsd_pkg::ANG_HALF) >>> ctsd_pkg::ANG_SHIFT;
        el_rnd = (el[POST_CELLS].ang + ctsd_pkg::ANG_HALF) >>> ctsd_pkg::ANG_SHIFT;
        if (el_rnd > ctsd_pkg::ANG_QUARTER_ACC)
        begin
            el_rnd = ctsd_pkg::ANG_QUARTER_ACC;
        end
        if (el_rnd < -ctsd_pkg::ANG_QUARTER_ACC)
        begin
            el_rnd = -ctsd_pkg::ANG_QUARTER_ACC;
        end

        fin.range       = sb.range;
        fin.azimuth     = ctsd_pkg::ANGLE_W'(az_rnd);
        fin.elevation   = ctsd_pkg::ANGLE_W'(el_rnd);
        fin.dir_x       = dir_value(dvx[POST_CELLS]);
        fin.dir_y       = dir_value(dvy[POST_CELLS]);
        fin.dir_z       = dir_value(dvz[POST_CELLS]);
        fin.near_origin = 1'b0;
        if (sb.vert)
        begin
            fin.azimuth   = '0;
            fin.elevation = sb.zneg ? -ctsd_pkg::ANG_QUARTER : ctsd_pkg::ANG_QUARTER;
        end
        if (sb.near)
        begin
            fin.azimuth     = '0;
            fin.elevation   = '0;
            fin.dir_x       = '0;
            fin.dir_y       = '0;
            fin.dir_z       = '0;
            fin.near_origin = 1'b1;
        end
    end

    // Output slot with a skid slot behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (result_ready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (v_reg[NV-1])
        begin
            if (out_v_reg && !result_ready)
            begin
                skid_v_reg <= 1'b1;
            end
            else
            begin
                out_v_reg <= 1'b1;
            end
        end
        else if (result_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (result_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (v_reg[NV-1])
        begin
            if (out_v_reg && !result_ready)
            begin
                skid_reg <= fin;
            end
            else
            begin
                out_reg <= fin;
            end
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

endmodule

// ----- hw/rtl/ctsd_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Cartesian to spherical direction: port checker
// Watches the handshakes and result beats at the top level ports.
// ============================================================================
module ctsd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              point_ready,
    input logic              result_valid,
    input logic              result_ready,
    input ctsd_pkg::result_t result
);

    // A stalled result beat keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

    // The input side only waits while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> result_valid)
    else $error("input stalled with no result pending");

    // Taking a result while stalled frees the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready && result_valid && result_ready |=> point_ready)
    else $error("input stayed stalled after a result beat was taken");

    // A point near the origin carries no angles and no direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.near_origin |->
            result.azimuth == '0 && result.elevation == '0 &&
            result.dir_x == '0 && result.dir_y == '0 && result.dir_z == '0)
    else $error("near-origin beat with nonzero angle or direction");

endmodule

bind cartesian_to_spherical_direction ctsd_checker u_ctsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_ready  (point_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ----- test/tb_cartesian_to_spherical_direction.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the Cartesian to spherical direction converter
// Sends directed and random points through the valid/ready input channel.
// Each accepted point is predicted in fixed point here: integer square root
// range, vectoring CORDIC azimuth and elevation, and rounded unit direction.
// Each result beat is checked against the oldest prediction. Input gaps and
// output stalls are random. min_range is rewritten over APB between phases,
// and its extremes are included.
// ============================================================================
module tb_cartesian_to_spherical_direction;
    import ctsd_pkg::*;

    localparam int  PIPE_DRAIN = 60;
    localparam int  COORD_MAX  = 8388607;
    localparam int  COORD_MIN  = -8388608;
    localparam logic [2:0] ADDR_MIN_RANGE = 3'd0;

    localparam longint ATAN_LUT [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_ready;
    point_t      point;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [COORD_W-1:0] thr_model;
    result_t            pending_results[$];
    int                 error_count;
    int                 beats_sent;
    int                 beats_checked;
    int                 near_seen;
    int                 settings_used;
    bit                 rx_quiet;
    bit                 tx_quiet;
    int                 stall_left;

    cartesian_to_spherical_direction dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC angle of (x, y), accumulated with pi equal to 2^31 and returned rounded with pi equal to 2^15.
    function automatic longint vector_angle(input longint y, input longint x);
        longint ang;
        longint t;
        longint xs;
        longint ys;
        ang = 0;
        x = x * (64'sd1 <<< GUARD_SHIFT);
        y = y * (64'sd1 <<< GUARD_SHIFT);
        if (x < 0)
        begin
            if (y >= 0)
            begin
                ang = 64'sd1 <<< 30;
                t = x; x = y; y = -t;
            end
            else
            begin
                ang = -(64'sd1 <<< 30);
                t = x; x = -y; y = t;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; ang = ang + ATAN_LUT[i];
            end
            else
            begin
                x = x - ys; y = y + xs; ang = ang - ATAN_LUT[i];
            end
        end
        return (ang + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    endfunction

    function automatic logic [DIR_W-1:0] unit_component(input longint c,
                                                        input longint unsigned r);
        longint unsigned q;
        longint unsigned m;
        m = (c < 0) ? -c : c;
        q = (m * (2 * DIR_ONE) + r) / (2 * r);
        if (q > DIR_ONE)
            q = DIR_ONE;
        return (c < 0) ? DIR_W'(-longint'(q)) : DIR_W'(q);
    endfunction

    function automatic result_t predict_spherical(input point_t p,
                                                  input logic [COORD_W-1:0] thr);
        result_t         res;
        longint          x;
        longint          y;
        longint          z;
        longint unsigned hsq;
        longint unsigned r;
        longint unsigned h;
        longint          el;
        longint          quarter;
        x = p.pos_x;
        y = p.pos_y;
        z = p.pos_z;
        quarter = 64'sd1 <<< (ANGLE_W - 2);
        hsq = x * x + y * y;
        r = int_sqrt(hsq + z * z);
        res = '0;
        res.range = r[COORD_W-1:0];
        if (r < thr || r == 0)
        begin
            res.near_origin = 1'b1;
            return res;
        end
        h = int_sqrt(hsq);
        if (x == 0 && y == 0)
        begin
            res.azimuth   = '0;
            res.elevation = (z < 0) ? ANGLE_W'(-quarter) : ANGLE_W'(quarter);
        end
        else
        begin
            res.azimuth = ANGLE_W'(vector_angle(y, x));
            el = vector_angle(z, longint'(h));
            if (el > quarter)
                el = quarter;
            if (el < -quarter)
                el = -quarter;
            res.elevation = ANGLE_W'(el);
        end
        res.dir_x = unit_component(x, r);
        res.dir_y = unit_component(y, r);
        res.dir_z = unit_component(z, r);
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_point(input point_t p);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        point       <= p;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
        pending_results = {pending_results, predict_spherical(p, thr_model)};
        beats_sent++;
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        point_t p;
        p.pos_x = COORD_W'(x);
        p.pos_y = COORD_W'(y);
        p.pos_z = COORD_W'(z);
        send_point(p);
    endtask

    task automatic drain_and_settle();
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_min_range(input logic [COORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MIN_RANGE;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        thr_model = value;
        settings_used++;
    endtask

    function automatic int rand_coord(input int mode);
        int k;
        int v;
        case (mode)
            0: v = $signed(24'($urandom()));
            1:
            begin
                k = $urandom_range(0, 22);
                v = $urandom_range(0, (1 << k));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        endcase
        return v;
    endfunction

    task automatic send_random_point();
        int mode;
        int x;
        int y;
        int z;
        mode = $urandom_range(0, 9);
        if (mode < 5)
        begin
            x = rand_coord(0); y = rand_coord(0); z = rand_coord(0);
        end
        else if (mode < 8)
        begin
            x = rand_coord(1); y = rand_coord(1); z = rand_coord(1);
        end
        else if (mode == 8)
        begin
            x = 0; y = 0; z = 0;
            case ($urandom_range(0, 2))
                0: x = rand_coord(1);
                1: y = rand_coord(1);
                default: z = rand_coord(1);
            endcase
            if ($urandom_range(0, 1))
                y = rand_coord(1);
        end
        else
        begin
            x = rand_coord(2); y = rand_coord(1); z = rand_coord(2);
        end
        send_xyz(x, y, z);
    endtask

    task automatic test_directed_points();
        send_xyz(0, 0, 0);
        send_xyz(COORD_MAX, COORD_MAX, COORD_MAX);
        send_xyz(COORD_MIN, COORD_MIN, COORD_MIN);
        send_xyz(COORD_MAX, COORD_MIN, COORD_MAX);
        send_xyz(COORD_MIN, COORD_MAX, COORD_MIN);
        send_xyz(0, 0, 65536);
        send_xyz(0, 0, -65536);
        send_xyz(0, 0, COORD_MIN);
        send_xyz(-65536, 0, 0);
        send_xyz(COORD_MIN, 0, 0);
        send_xyz(-65536, -1, 0);
        send_xyz(-65536, 1, 0);
        send_xyz(65536, 0, 0);
        send_xyz(0, -65536, 0);
        send_xyz(1, 0, 0);
        send_xyz(6, 0, 0);
        send_xyz(7, 0, 0);
        send_xyz(4, 4, 4);
        send_xyz(5, -5, 0);
        send_xyz(1, 1, COORD_MAX);
        send_xyz(-1, 0, COORD_MIN);
        send_xyz(COORD_MAX, 0, -1);
        drain_and_settle();
    endtask

    task automatic test_threshold_extremes();
        write_min_range('0);
        send_xyz(0, 0, 0);
        send_xyz(1, 0, 0);
        send_xyz(0, -1, 1);
        drain_and_settle();
        write_min_range({COORD_W{1'b1}});
        send_xyz(COORD_MIN, COORD_MIN, COORD_MIN);
        send_xyz(COORD_MAX, 0, 0);
        drain_and_settle();
        write_min_range(COORD_W'(65536));
        send_xyz(65535, 0, 0);
        send_xyz(65536, 0, 0);
        send_xyz(0, 0, -65536);
        drain_and_settle();
    endtask

    task automatic test_random_points();
        logic [COORD_W-1:0] thr_list[5];
        thr_list = '{COORD_W'(7), COORD_W'(0), COORD_W'(4096),
                     COORD_W'(3000000), {COORD_W{1'b1}}};
        for (int s = 0; s < 5; s++)
        begin
            write_min_range(thr_list[s]);
            for (int n = 0; n < 380; n++)
            begin
                tx_quiet = (n >= 150 && n < 200);
                rx_quiet = (n >= 100 && n < 180);
                send_random_point();
            end
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
            drain_and_settle();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (rx_quiet)
            result_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                          : $urandom_range(0, 2);
        end
    end

    task automatic check_field(input string name, input longint exp_v,
                               input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no point outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("range", want.range, result.range);
                check_field("azimuth", want.azimuth, result.azimuth);
                check_field("elevation", want.elevation, result.elevation);
                check_field("dir_x", want.dir_x, result.dir_x);
                check_field("dir_y", want.dir_y, result.dir_y);
                check_field("dir_z", want.dir_z, result.dir_z);
                check_field("near_origin", want.near_origin, result.near_origin);
                beats_checked++;
                if (result.near_origin)
                    near_seen++;
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("FAIL cartesian_to_spherical_direction");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        point_valid = 1'b0;
        point       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        thr_model   = MIN_RANGE_RST;
        error_count = 0;
        beats_sent  = 0;
        beats_checked = 0;
        near_seen   = 0;
        settings_used = 1;
        rx_quiet    = 1'b0;
        tx_quiet    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_points();
        test_threshold_extremes();
        test_random_points();

        if (pending_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_results.size());
            error_count++;
        end
        $display("Sent %0d points and checked %0d result beats, %0d near the origin.",
                 beats_sent, beats_checked, near_seen);
        $display("Covered %0d min_range settings, including 0 and full scale.",
                 settings_used);
        if (error_count == 0)
            $display("PASS cartesian_to_spherical_direction");
        else
            $display("FAIL cartesian_to_spherical_direction");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ctsd_pkg.sv
hw/rtl/ctsd_sqrt_cell.sv
hw/rtl/ctsd_cordic_cell.sv
hw/rtl/ctsd_div_cell.sv
hw/rtl/cartesian_to_spherical_direction.sv
hw/rtl/ctsd_checker.sv
test/tb_cartesian_to_spherical_direction.sv
